[src/bcpu_pkg.sv]
// Package for the byte CPU core: opcode decode types, sequencer states and codes.
// No dependencies.
package bcpu_pkg;

  localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;
  localparam logic [7:0]  SIGN_BIT     = 8'h80;
  localparam int          MEM_AW       = 16;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_EXEC  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OUT_RUN   = 2'd0,
    OUT_HALT  = 2'd1,
    OUT_FAULT = 2'd2
  } outcome_t;

  typedef enum logic [3:0] {
    AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
    AM_INDX, AM_INDY, AM_ACC, AM_JMP, AM_JMPI, AM_JSR, AM_BAD
  } amode_t;

  typedef enum logic [1:0] {
    TG_A, TG_X, TG_Y, TG_MEM
  } target_t;

  typedef struct packed {
    amode_t  amode;
    target_t tgt;
  } decode_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_OP, ST_B1, ST_B2, ST_PLO, ST_PHI,
    ST_JLO, ST_JHI, ST_PUSH, ST_DATA, ST_DONE
  } state_t;

  function automatic decode_t decode_op(logic [7:0] op);
    decode_t d;
    d.tgt = TG_A;
    case (op)
      8'hA9: d.amode = AM_IMM;
      8'hA5: d.amode = AM_ZP;
      8'hB5: d.amode = AM_ZPX;
      8'hAD: d.amode = AM_ABS;
      8'hBD: d.amode = AM_ABSX;
      8'hB9: d.amode = AM_ABSY;
      8'hA1: d.amode = AM_INDX;
      8'hB1: d.amode = AM_INDY;
      8'hA2: begin d.amode = AM_IMM;  d.tgt = TG_X; end
      8'hA6: begin d.amode = AM_ZP;   d.tgt = TG_X; end
      8'hB6: begin d.amode = AM_ZPY;  d.tgt = TG_X; end
      8'hAE: begin d.amode = AM_ABS;  d.tgt = TG_X; end
      8'hBE: begin d.amode = AM_ABSY; d.tgt = TG_X; end
      8'hA0: begin d.amode = AM_IMM;  d.tgt = TG_Y; end
      8'hA4: begin d.amode = AM_ZP;   d.tgt = TG_Y; end
      8'hB4: begin d.amode = AM_ZPX;  d.tgt = TG_Y; end
      8'hAC: begin d.amode = AM_ABS;  d.tgt = TG_Y; end
      8'hBC: begin d.amode = AM_ABSX; d.tgt = TG_Y; end
      8'h4A: d.amode = AM_ACC;
      8'h46: begin d.amode = AM_ZP;   d.tgt = TG_MEM; end
      8'h56: begin d.amode = AM_ZPX;  d.tgt = TG_MEM; end
      8'h4E: begin d.amode = AM_ABS;  d.tgt = TG_MEM; end
      8'h5E: begin d.amode = AM_ABSX; d.tgt = TG_MEM; end
      8'h20: d.amode = AM_JSR;
      8'h4C: d.amode = AM_JMP;
      8'h6C: d.amode = AM_JMPI;
      default: d.amode = AM_BAD;
    endcase
    return d;
  endfunction

  // Z/N update on a loaded or shifted value, other flags kept.
  function automatic logic [7:0] set_zn(logic [7:0] p, logic [7:0] v);
    logic [7:0] r;
    r = p & 8'h7D;
    r[1] = (v == 8'h00);
    r[7] = |(v & SIGN_BIT);
    return r;
  endfunction

endpackage

[src/bcpu_if.sv]
// Valid/ready channel interfaces for the byte CPU core: request and result.
// No dependencies.
interface bcpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] mem_address;
  logic [7:0]  mem_data;
  modport source (output valid, mode, mem_address, mem_data, input ready);
  modport sink   (input valid, mode, mem_address, mem_data, output ready);
endinterface

interface bcpu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  accumulator;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [15:0] program_counter;
  logic [7:0]  stack_pointer;
  logic [7:0]  flags;
  logic [31:0] tick_count;
  logic [7:0]  read_data;
  logic [1:0]  outcome;
  modport source (output valid, accumulator, index_x, index_y, program_counter,
                  stack_pointer, flags, tick_count, read_data, outcome, input ready);
  modport sink   (input valid, accumulator, index_x, index_y, program_counter,
                  stack_pointer, flags, tick_count, read_data, outcome, output ready);
endinterface

[src/byte_cpu_load_shift_jump_core.sv]
// Byte CPU core: loads, LSR, JMP/JSR over a 64 KiB single-port memory.
// Depends on bcpu_pkg and bcpu_if.
// Each transaction runs from accept to result; an execute walks through states set by the
// number of single-port memory accesses its addressing mode needs, and once stopped makes none.
// Throughput: one transaction at a time; the single memory port sets the step count.
// Reset: registers to power-on values, then a clearing pass zeroes all 65536 memory bytes,
// during which no transaction is accepted.
module byte_cpu_load_shift_jump_core (
  input logic clk,
  input logic rst_n,
  bcpu_in_if.sink    in_ch,
  bcpu_out_if.source out_ch
);
  import bcpu_pkg::*;

  logic [7:0] mem [0:(1<<MEM_AW)-1];

  state_t      state_r, state_nxt;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic [15:0] pc_r, pc_nxt, ea_r, ea_nxt;
  logic [31:0] tick_r;
  logic [1:0]  tinc;
  logic [1:0]  stop_r, stop_nxt;
  decode_t     dec_r, dec_nxt;
  logic [7:0]  lo_r, lo_nxt, ptr_r, ptr_nxt, rd_r, rd_nxt, rdata_r;
  logic [15:0] clr_r, clr_nxt;
  logic [15:0] maddr;
  logic        mwe;
  logic [7:0]  mwd;
  logic [7:0]  zsum, zinc, shv;
  logic [15:0] word, wsum;
  decode_t     dop;

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    rdata_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      a_r <= '0; x_r <= '0; y_r <= '0; p_r <= '0;
      pc_r <= RESET_VECTOR; sp_r <= 8'hFF;
      tick_r <= '0; stop_r <= OUT_RUN; clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; p_r <= p_nxt;
      pc_r <= pc_nxt; sp_r <= sp_nxt;
      tick_r <= tick_r + {30'd0, tinc};
      stop_r <= stop_nxt; clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt; lo_r <= lo_nxt; ptr_r <= ptr_nxt; ea_r <= ea_nxt; rd_r <= rd_nxt;
  end

  assign dop  = decode_op(rdata_r);
  assign word = {rdata_r, lo_r};
  assign shv  = rdata_r >> 1;

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; p_nxt = p_r;
    pc_nxt = pc_r; sp_nxt = sp_r; stop_nxt = stop_r; clr_nxt = clr_r;
    dec_nxt = dec_r; lo_nxt = lo_r; ptr_nxt = ptr_r; ea_nxt = ea_r; rd_nxt = rd_r;
    tinc = 2'd0;
    maddr = pc_r; mwe = 1'b0; mwd = 8'h00;
    zsum = 8'h00; zinc = 8'h00; wsum = 16'h0000;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        maddr = clr_r; mwe = 1'b1;
        clr_nxt = clr_r + 16'd1;
        if (clr_r == 16'hFFFF) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_nxt = 8'h00;
        if (in_ch.valid) begin
          state_nxt = ST_DONE;
          case (mode_t'(in_ch.mode))
            MODE_WRITE: begin
              maddr = in_ch.mem_address; mwe = 1'b1; mwd = in_ch.mem_data;
            end
            MODE_READ: begin
              maddr = in_ch.mem_address; state_nxt = ST_RD;
            end
            MODE_EXEC: begin
              if (stop_r == OUT_RUN) begin
                pc_nxt = pc_r + 16'd1; tinc = 2'd1; state_nxt = ST_OP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_nxt = rdata_r; state_nxt = ST_DONE;
      end
      ST_OP: begin
        dec_nxt = dop;
        state_nxt = ST_DONE;
        case (dop.amode)
          AM_BAD: stop_nxt = (rdata_r == 8'h00) ? OUT_HALT : OUT_FAULT;
          AM_ACC: begin
            a_nxt = a_r >> 1;
            p_nxt = set_zn({p_r[7:1], a_r[0]}, a_r >> 1);
            tinc = 2'd1;
          end
          default: begin
            pc_nxt = pc_r + 16'd1; tinc = 2'd1; state_nxt = ST_B1;
          end
        endcase
      end
      ST_B1: begin
        lo_nxt = rdata_r;
        state_nxt = ST_DATA;
        case (dec_r.amode)
          AM_IMM: begin
            state_nxt = ST_DONE;
            p_nxt = set_zn(p_r, rdata_r);
            case (dec_r.tgt)
              TG_X: x_nxt = rdata_r;
              TG_Y: y_nxt = rdata_r;
              default: a_nxt = rdata_r;
            endcase
          end
          AM_ZP: begin
            ea_nxt = {8'h00, rdata_r}; maddr = ea_nxt; tinc = 2'd1;
          end
          AM_ZPX, AM_ZPY: begin
            zsum = rdata_r + ((dec_r.amode == AM_ZPY) ? y_r : x_r);
            ea_nxt = {8'h00, zsum}; maddr = ea_nxt; tinc = 2'd2;
          end
          AM_INDX: begin
            zsum = rdata_r + x_r;
            ptr_nxt = zsum; maddr = {8'h00, zsum}; tinc = 2'd2; state_nxt = ST_PLO;
          end
          AM_INDY: begin
            ptr_nxt = rdata_r; maddr = {8'h00, rdata_r}; tinc = 2'd1; state_nxt = ST_PLO;
          end
          default: begin
            pc_nxt = pc_r + 16'd1; tinc = 2'd1; state_nxt = ST_B2;
          end
        endcase
      end
      ST_B2: begin
        state_nxt = ST_DATA;
        case (dec_r.amode)
          AM_ABS: begin
            ea_nxt = word; maddr = word; tinc = 2'd1;
          end
          AM_ABSX, AM_ABSY: begin
            wsum = word + {8'h00, (dec_r.amode == AM_ABSY) ? y_r : x_r};
            ea_nxt = wsum; maddr = wsum; tinc = 2'd2;
          end
          AM_JMP: begin
            pc_nxt = word; state_nxt = ST_DONE;
          end
          AM_JMPI: begin
            ea_nxt = word; maddr = word; state_nxt = ST_JLO;
          end
          default: begin
            wsum = pc_r - 16'd1;
            ea_nxt = word; maddr = {STACK_PAGE, sp_r}; mwe = 1'b1; mwd = wsum[15:8];
            sp_nxt = sp_r - 8'd1; state_nxt = ST_PUSH;
          end
        endcase
      end
      ST_PUSH: begin
        wsum = pc_r - 16'd1;
        maddr = {STACK_PAGE, sp_r}; mwe = 1'b1; mwd = wsum[7:0];
        sp_nxt = sp_r - 8'd1; tinc = 2'd3; pc_nxt = ea_r; state_nxt = ST_DONE;
      end
      ST_PLO: begin
        lo_nxt = rdata_r;
        zinc = ptr_r + 8'd1;
        maddr = {8'h00, zinc}; tinc = 2'd1; state_nxt = ST_PHI;
      end
      ST_PHI: begin
        state_nxt = ST_DATA;
        if (dec_r.amode == AM_INDY) begin
          wsum = word + {8'h00, y_r}; tinc = 2'd2;
        end else begin
          wsum = word; tinc = 2'd1;
        end
        ea_nxt = wsum; maddr = wsum;
      end
      ST_JLO: begin
        lo_nxt = rdata_r;
        maddr = ea_r + 16'd1; state_nxt = ST_JHI;
      end
      ST_JHI: begin
        pc_nxt = word; tinc = 2'd2; state_nxt = ST_DONE;
      end
      ST_DATA: begin
        state_nxt = ST_DONE;
        case (dec_r.tgt)
          TG_MEM: begin
            p_nxt = set_zn({p_r[7:1], rdata_r[0]}, shv);
            maddr = ea_r; mwe = 1'b1; mwd = shv; tinc = 2'd2;
          end
          TG_X: begin x_nxt = rdata_r; p_nxt = set_zn(p_r, rdata_r); end
          TG_Y: begin y_nxt = rdata_r; p_nxt = set_zn(p_r, rdata_r); end
          default: begin a_nxt = rdata_r; p_nxt = set_zn(p_r, rdata_r); end
        endcase
      end
      ST_DONE: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.accumulator     = a_r;
  assign out_ch.index_x         = x_r;
  assign out_ch.index_y         = y_r;
  assign out_ch.program_counter = pc_r;
  assign out_ch.stack_pointer   = sp_r;
  assign out_ch.flags           = p_r;
  assign out_ch.tick_count      = tick_r;
  assign out_ch.read_data       = rd_r;
  assign out_ch.outcome         = stop_r;

endmodule
